// File: hw/rtl/ecl_pkg.sv
package ecl_pkg;

  // Auxiliary field size and the widths that follow from it
  localparam int AUX_LEN = 512;
  localparam int AuxIdxW = $clog2(AUX_LEN);
  localparam int AuxCntW = $clog2(AUX_LEN + 1);

  localparam int NumFields = 3;

  localparam logic [15:0] AckLimitReset = 16'd32;

  // Byte codes
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChPlus      = 8'h2B;
  localparam logic [7:0] ChMinus     = 8'h2D;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0D;

  typedef enum logic [1:0] {
    PhSkip,
    PhDigits,
    PhDone
  } num_phase_t;

  // One numeric field's update for the current beat
  typedef struct packed {
    logic       clear;
    logic       feed;
    logic [7:0] data;
  } num_step_t;

  // Line control towards the three converters
  typedef struct packed {
    logic                 clear;
    logic [NumFields-1:0] feed;
    logic [7:0]           data;
  } num_ctl_t;

  typedef struct packed {
    logic                aux_valid;
    logic [AuxIdxW-1:0]  aux_index;
    logic [7:0]          aux_data;
    logic                line_done;
    logic signed [31:0]  command_number;
    logic signed [31:0]  pin_number;
    logic signed [31:0]  value_number;
    logic [AuxCntW-1:0]  aux_length;
    logic                aux_overflow;
    logic                rx_ack;
  } result_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == ChSpace) || (b >= ChTab && b <= ChCr);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

endpackage

// File: hw/rtl/ecl_if.sv
interface ecl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ecl_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] ack_byte_limit;

  modport source (output valid, output ack_byte_limit, input ready);
  modport sink (input valid, input ack_byte_limit, output ready);
endinterface

interface ecl_result_if;
  logic                            valid;
  logic                            ready;
  logic                            aux_valid;
  logic [ecl_pkg::AuxIdxW-1:0]     aux_index;
  logic [7:0]                      aux_data;
  logic                            line_done;
  logic signed [31:0]              command_number;
  logic signed [31:0]              pin_number;
  logic signed [31:0]              value_number;
  logic [ecl_pkg::AuxCntW-1:0]     aux_length;
  logic                            aux_overflow;
  logic                            rx_ack;

  modport source (
    output valid, output aux_valid, output aux_index, output aux_data,
    output line_done, output command_number, output pin_number,
    output value_number, output aux_length, output aux_overflow,
    output rx_ack, input ready
  );
  modport sink (
    input valid, input aux_valid, input aux_index, input aux_data,
    input line_done, input command_number, input pin_number,
    input value_number, input aux_length, input aux_overflow,
    input rx_ack, output ready
  );
endinterface

// File: hw/rtl/ecl_atoi.sv
// Running atoi of one numeric field.
module ecl_atoi (
  input  logic                clk,
  input  logic                rst,
  input  ecl_pkg::num_step_t  step,
  output logic signed [31:0]  value
);

  ecl_pkg::num_phase_t phase, phase_next;
  logic                negative, negative_next;
  logic [31:0]         acc, acc_next;
  logic [31:0]         digit;
  logic                is_dig;

  assign digit  = {28'd0, step.data[3:0]};
  assign is_dig = ecl_pkg::is_digit(step.data);

  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    acc_next      = acc;
    if (step.clear) begin
      phase_next    = ecl_pkg::PhSkip;
      negative_next = 1'b0;
      acc_next      = '0;
    end else if (step.feed) begin
      case (phase)
        ecl_pkg::PhSkip: begin
          if (ecl_pkg::is_space(step.data)) begin
            phase_next = ecl_pkg::PhSkip;
          end else if (step.data == ecl_pkg::ChPlus) begin
            phase_next = ecl_pkg::PhDigits;
          end else if (step.data == ecl_pkg::ChMinus) begin
            phase_next    = ecl_pkg::PhDigits;
            negative_next = 1'b1;
          end else if (is_dig) begin
            phase_next = ecl_pkg::PhDigits;
            acc_next   = digit;
          end else begin
            phase_next = ecl_pkg::PhDone;
          end
        end
        ecl_pkg::PhDigits: begin
          if (is_dig) begin
            // acc * 10 + digit, modulo 2^32
            acc_next = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + digit;
          end else begin
            phase_next = ecl_pkg::PhDone;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_comb begin
    value = negative ? -$signed(acc) : $signed(acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= ecl_pkg::PhSkip;
      negative <= 1'b0;
      acc      <= '0;
    end else begin
      phase    <= phase_next;
      negative <= negative_next;
      acc      <= acc_next;
    end
  end

endmodule

// File: hw/rtl/ecl_line.sv
// Line framing, escapes, auxiliary field and receive counter.
module ecl_line (
  input  logic                clk,
  input  logic                rst,
  input  logic                proc,
  input  logic [7:0]          data,
  input  logic [15:0]         ack_limit,
  input  logic signed [31:0]  num0,
  input  logic signed [31:0]  num1,
  input  logic signed [31:0]  num2,
  output ecl_pkg::num_ctl_t   ctl,
  output ecl_pkg::result_t    res
);

  logic                        escape_pending, escape_pending_next;
  logic [1:0]                  field_number, field_number_next;
  logic                        first_nonempty, first_nonempty_next;
  logic [ecl_pkg::AuxCntW-1:0] aux_count, aux_count_next;
  logic                        aux_dropped, aux_dropped_next;
  logic [15:0]                 received_count, received_count_next;

  logic        is_nl, is_bs, is_dot, in_num;
  logic        store, ended;
  logic [15:0] rc_inc;

  assign is_nl  = (data == ecl_pkg::ChNewline);
  assign is_bs  = (data == ecl_pkg::ChBackslash);
  assign is_dot = (data == ecl_pkg::ChDot);
  assign in_num = (field_number < 2'(ecl_pkg::NumFields));
  assign rc_inc = received_count + 16'd1;

  always_comb begin
    escape_pending_next = escape_pending;
    field_number_next   = field_number;
    first_nonempty_next = first_nonempty;
    aux_count_next      = aux_count;
    aux_dropped_next    = aux_dropped;
    received_count_next = received_count;
    store               = 1'b0;
    ended               = 1'b0;
    res                 = '0;
    ctl                 = '0;
    ctl.data            = data;

    if (proc) begin
      if (is_nl || is_bs) begin
        if (escape_pending) begin
          store               = 1'b1;
          escape_pending_next = 1'b0;
        end else if (is_nl) begin
          ended = 1'b1;
        end else begin
          escape_pending_next = 1'b1;
        end
      end else if (is_dot && in_num) begin
        escape_pending_next = 1'b0;
        field_number_next   = field_number + 2'd1;
      end else if (is_dot) begin
        // a dot in the aux field is data and keeps the escape
        store = 1'b1;
      end else begin
        escape_pending_next = 1'b0;
        store               = 1'b1;
      end

      if (store) begin
        if (in_num) begin
          if (field_number == 2'd0) begin
            first_nonempty_next = 1'b1;
          end
          ctl.feed[field_number] = 1'b1;
        end else if (aux_count < ecl_pkg::AuxCntW'(ecl_pkg::AUX_LEN)) begin
          res.aux_valid  = 1'b1;
          res.aux_index  = aux_count[ecl_pkg::AuxIdxW-1:0];
          res.aux_data   = data;
          aux_count_next = aux_count + ecl_pkg::AuxCntW'(1);
        end else begin
          aux_dropped_next = 1'b1;
        end
      end

      res.aux_overflow = aux_dropped_next;

      if (ended) begin
        if (field_number != 2'd0 || first_nonempty) begin
          res.line_done      = 1'b1;
          res.command_number = num0;
          res.pin_number     = num1;
          res.value_number   = num2;
          res.aux_length     = aux_count;
        end
        ctl.clear           = 1'b1;
        field_number_next   = 2'd0;
        first_nonempty_next = 1'b0;
        aux_count_next      = '0;
        aux_dropped_next    = 1'b0;
      end

      if (rc_inc >= ack_limit) begin
        res.rx_ack          = 1'b1;
        received_count_next = '0;
      end else begin
        received_count_next = rc_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      field_number   <= 2'd0;
      first_nonempty <= 1'b0;
      aux_count      <= '0;
      aux_dropped    <= 1'b0;
      received_count <= '0;
    end else begin
      escape_pending <= escape_pending_next;
      field_number   <= field_number_next;
      first_nonempty <= first_nonempty_next;
      aux_count      <= aux_count_next;
      aux_dropped    <= aux_dropped_next;
      received_count <= received_count_next;
    end
  end

endmodule

// File: hw/rtl/escaped_command_line_parser.sv
// Escaped command line parser.
// rx: one received byte per beat (valid/ready). Lines end at an unescaped
//   newline and split into command.pin.value.aux; backslash escapes a
//   newline or a backslash. The numeric fields are converted atoi style.
// result: exactly one beat per rx beat, carrying the stored aux byte (if
//   any), the line-end numbers when a non-empty line finishes, the overflow
//   flag and the receive acknowledge.
// cfg: write channel for ack_byte_limit (reset 32); always ready. Write it
//   only while no byte is in flight.
// Path: a taken byte passes the input register, then the result register,
//   to give its result beat. Throughput: one byte per cycle while the
//   receiver takes results, as the line unit updates its state per byte.
// Reset (rst, synchronous): both registers empty, line state, escape,
//   receive counter cleared, limit back to 32.
// Receiver stall: the result register holds; an empty input register still
//   takes one more byte, then rx.ready drops until the result is taken.
module escaped_command_line_parser (
  input  logic     clk,
  input  logic     rst,
  ecl_byte_if.sink     rx,
  ecl_cfg_if.sink      cfg,
  ecl_result_if.source result
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // result register
  logic             out_valid;
  ecl_pkg::result_t out_res;

  logic [15:0] ack_limit;

  logic                     advance;   // result register can load
  logic                     proc;      // byte processed this cycle
  ecl_pkg::num_ctl_t        ctl;
  ecl_pkg::result_t         res_d;
  logic signed [31:0]       num [ecl_pkg::NumFields];

  assign advance  = !out_valid || result.ready;
  assign proc     = in_valid && advance;
  assign rx.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_limit <= ecl_pkg::AckLimitReset;
    end else if (cfg.valid) begin
      ack_limit <= cfg.ack_byte_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // one converter per numeric field
  for (genvar i = 0; i < ecl_pkg::NumFields; i++) begin : g_num
    ecl_pkg::num_step_t step;
    always_comb begin
      step.clear = ctl.clear;
      step.feed  = ctl.feed[i];
      step.data  = ctl.data;
    end
    ecl_atoi u_atoi (
      .clk   (clk),
      .rst   (rst),
      .step  (step),
      .value (num[i])
    );
  end

  ecl_line u_line (
    .clk       (clk),
    .rst       (rst),
    .proc      (proc),
    .data      (in_byte),
    .ack_limit (ack_limit),
    .num0      (num[0]),
    .num1      (num[1]),
    .num2      (num[2]),
    .ctl       (ctl),
    .res       (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_res <= res_d;
    end
  end

  assign result.valid          = out_valid;
  assign result.aux_valid      = out_res.aux_valid;
  assign result.aux_index      = out_res.aux_index;
  assign result.aux_data       = out_res.aux_data;
  assign result.line_done      = out_res.line_done;
  assign result.command_number = out_res.command_number;
  assign result.pin_number     = out_res.pin_number;
  assign result.value_number   = out_res.value_number;
  assign result.aux_length     = out_res.aux_length;
  assign result.aux_overflow   = out_res.aux_overflow;
  assign result.rx_ack         = out_res.rx_ack;

  // a line end never stores an aux byte in the same beat
  a_done_no_aux: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.line_done |-> !out_res.aux_valid)
    else $error("line end with aux byte");

  // once bytes are dropped the aux field is full, so nothing more is stored
  a_drop_no_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.aux_valid |-> !out_res.aux_overflow)
    else $error("aux byte stored while overflowed");

  // both registers full and stalled: no further byte taken
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !result.ready |-> !rx.ready)
    else $error("byte taken with pipeline full");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule
